// ----- rtl/crm_pkg.sv -----
// package for the checked register map
// request and status codes, descriptor layout; no dependencies
package crm_pkg;
  localparam int ADDR_BITS_DEF  = 10;
  localparam int MAX_FIELDS_DEF = 8;

  localparam logic [1:0] REQ_DEFINE = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_WRITE  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOREG   = 3'd1;
  localparam logic [2:0] ST_BELOW   = 3'd2;
  localparam logic [2:0] ST_ABOVE   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;
  localparam logic [2:0] ST_SKIP    = 3'd5;

  // descriptor: shape[11:0], low bound[45:12], high bound[79:46]
  localparam int DESC_W = 80;

  typedef struct packed {
    logic        sgn;
    logic [5:0]  len;
    logic [4:0]  start;
  } shape_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  bad_field;
    logic [32:0] bad_value;
  } chk_t;
endpackage

// ----- rtl/crm_ram.sv -----
// generic single-port-write, single-read synchronous ram
// registered read, no dependencies
module crm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/crm_check.sv -----
// one field check: extract, sign extend, compare with bounds
// uses crm_pkg
module crm_check (
  input  logic [31:0]        word,
  input  logic [crm_pkg::DESC_W-1:0] desc,
  output logic               fail_lo,
  output logic               fail_hi,
  output logic [32:0]        value
);
  import crm_pkg::*;
  shape_t sh;
  logic [5:0] len;
  logic [31:0] mask, raw;
  logic [33:0] lo, hi;
  logic sbit;
  always_comb begin
    sh = desc[11:0];
    lo = desc[45:12];
    hi = desc[79:46];
    len = sh.len;
    mask = (len >= 6'd32) ? 32'hffff_ffff : ((32'd1 << len[4:0]) - 32'd1);
    raw = (word >> sh.start) & mask;
    sbit = sh.sgn && raw[(len >= 6'd32) ? 5'd31 : 5'(len - 6'd1)];
    value = {1'b0, raw} | (sbit ? ~{1'b0, mask} : 33'd0);
    fail_lo = lo[33] && ($signed(value) < $signed(lo[32:0]));
    fail_hi = hi[33] && ($signed(value) > $signed(hi[32:0]));
  end
endmodule

// ----- rtl/checked_register_map_unit.sv -----
// checked register map top level: sequencer, reg and descriptor memories
// uses crm_pkg, crm_ram, crm_check
//
// channel | dir | handshake        | payload
// in      | in  | in_tvalid/tready | req,addr,wdata,first,field descriptor
// out     | out | out_tvalid/tready| rdata,status,bad_field,bad_value
//
// define/read: lookup, act, result. write: lookup, act, then one field step per
// field checked, up to the first failing one, then result. reset clears the
// register memory before the first item is taken. one item at a time;
// in_tready is low while a result waits.
module checked_register_map_unit #(
  parameter int ADDR_BITS  = crm_pkg::ADDR_BITS_DEF,
  parameter int MAX_FIELDS = crm_pkg::MAX_FIELDS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // req_type[1:0] addr[11:2] wdata[43:12] field_start[48:44] field_length[54:49]
  // field_signed[55] field_has_min[56] field_min[89:57] field_has_max[90]
  // field_max[123:91], zero pad to 128
  input  logic [127:0] in_tdata,
  // block_first
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // rdata[31:0] status[34:32] bad_field[37:35] bad_value[70:38], zero pad to 72
  output logic [71:0]  out_tdata
);
  import crm_pkg::*;
  localparam int NREGS = 1 << ADDR_BITS;
  localparam int CW = $clog2(MAX_FIELDS + 1);
  localparam int RW = 32 + 1 + CW;
  localparam int DD = NREGS * MAX_FIELDS;
  localparam int DA = $clog2(DD);

  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_LOOK = 3'd2,
                         S_ACT = 3'd3, S_FLD = 3'd4, S_OUT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [ADDR_BITS-1:0] clr_r, clr_nxt;
  logic [127:0] req_r;
  logic first_r, berr_r, berr_nxt;
  logic [RW-1:0] ent_r, ent_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [71:0] res_r, res_nxt;

  logic [1:0] req;
  logic [ADDR_BITS-1:0] a;
  logic [31:0] wd;
  assign req = req_r[1:0];
  assign a = ADDR_BITS'(req_r[11:2]);
  assign wd = req_r[43:12];

  logic rwe, dwe;
  logic [ADDR_BITS-1:0] rwa;
  logic [RW-1:0] rwd, rrd;
  logic [DA-1:0] dwa, dra;
  logic [DESC_W-1:0] dwd, drd;
  logic [CW-1:0] cnt;
  logic ex;
  logic [31:0] word;
  assign {word, ex, cnt} = rrd;

  crm_ram #(.WIDTH(RW), .DEPTH(NREGS)) u_regs (
    .clk(clk), .we(rwe), .waddr(rwa), .wdata(rwd), .raddr(a), .rdata(rrd));
  crm_ram #(.WIDTH(DESC_W), .DEPTH(DD)) u_desc (
    .clk(clk), .we(dwe), .waddr(dwa), .wdata(dwd), .raddr(dra), .rdata(drd));

  logic flo, fhi;
  logic [32:0] val;
  crm_check u_chk (.word(wd), .desc(drd), .fail_lo(flo), .fail_hi(fhi), .value(val));

  logic [5:0] len_in;
  always_comb begin
    len_in = req_r[54:49];
    if (len_in == 6'd0) len_in = 6'd1;
    if (len_in > 6'd32) len_in = 6'd32;
    dwd = {req_r[90], req_r[123:91], req_r[56], req_r[89:57],
           req_r[55], len_in, req_r[48:44]};
  end

  function automatic logic [DA-1:0] eidx(logic [ADDR_BITS-1:0] ad, logic [CW-1:0] i);
    eidx = DA'(ad) * DA'(MAX_FIELDS) + DA'(i);
  endfunction

  assign dwa = eidx(a, cnt);
  assign dra = eidx(a, idx_nxt);

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    berr_nxt = berr_r;
    ent_nxt = ent_r;
    idx_nxt = idx_r;
    res_nxt = res_r;
    rwe = 1'b0;
    rwa = a;
    rwd = rrd;
    dwe = 1'b0;
    unique case (state_r)
      S_CLR: begin
        rwe = 1'b1;
        rwa = clr_r;
        rwd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_BITS'(NREGS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        idx_nxt = '0;
        if (in_tvalid) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_ACT;
        idx_nxt = '0;
      end
      S_ACT: begin
        res_nxt = '0;
        ent_nxt = rrd;
        idx_nxt = '0;
        state_nxt = S_OUT;
        if (req == REQ_DEFINE) begin
          if (cnt >= CW'(MAX_FIELDS)) res_nxt[34:32] = ST_FULL;
          else begin
            dwe = 1'b1;
            rwe = 1'b1;
            rwd = {word, 1'b1, cnt + 1'b1};
          end
        end else if (req != REQ_NONE) begin
          if (first_r) berr_nxt = 1'b0;
          if (berr_r && !first_r) res_nxt[34:32] = ST_SKIP;
          else if (!ex) begin
            res_nxt[34:32] = ST_NOREG;
            berr_nxt = 1'b1;
          end else if (req == REQ_READ) res_nxt[31:0] = word;
          else if (cnt == '0) begin
            rwe = 1'b1;
            rwd = {wd, ex, cnt};
          end else state_nxt = S_FLD;
        end
      end
      S_FLD: begin
        idx_nxt = idx_r + 1'b1;
        if (flo || fhi) begin
          res_nxt[34:32] = flo ? ST_BELOW : ST_ABOVE;
          res_nxt[37:35] = 3'(idx_r);
          res_nxt[70:38] = val;
          berr_nxt = 1'b1;
          state_nxt = S_OUT;
        end else if (idx_r + 1'b1 >= ent_r[CW-1:0]) begin
          rwe = 1'b1;
          rwd = {wd, ent_r[CW], ent_r[CW-1:0]};
          state_nxt = S_OUT;
        end
      end
      S_OUT: if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      berr_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      berr_r <= berr_nxt;
    end
    if (state_r == S_IDLE && in_tvalid) begin
      req_r <= in_tdata;
      first_r <= in_tuser;
    end
    ent_r <= ent_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {1'b0, res_r[70:0]};

  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("ready and valid together");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken");
  a_fld: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLD) |-> (idx_r < ent_r[CW-1:0]))
    else $error("field index past count");
endmodule
